/* rtl/sbq_pkg.sv */
// ============================================================================
// sbq_pkg
// Types and constants shared by the strict-priority band queue.
// ============================================================================
package sbq_pkg;

    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_MAP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_CAPACITY = 1'd1;

    localparam logic [31:0] MAP_RESET = 32'h5555_09A4;
    localparam logic [6:0]  CAP_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] packet_data;
        logic        has_priority;
        logic [3:0]  priority_req;
        logic        filter_matched;
        logic [3:0]  filter_class;
    } in_word_t;

    typedef struct packed {
        logic        accepted;
        logic        out_valid;
        logic [31:0] out_data;
        logic [1:0]  out_band;
    } out_word_t;

    // per-item decision handed from the scheduler to the result stage
    typedef struct packed {
        logic       accepted;
        logic       found;
        logic [1:0] band;
    } sched_res_t;

endpackage

/* rtl/strict_priority_band_queue_core.sv */
// ============================================================================
// strict_priority_band_queue_core
// Strict-priority multi-band packet queue with enqueue, dequeue and peek.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one operation word (enqueue, dequeue, peek).
//   m_valid/m_ready/m_data return exactly one result word per operation.
//   cfg_we/cfg_index/cfg_wdata write priority_map (0) or band_capacity (1);
//   write only while the queue is idle.
// Timing:
//   One operation per cycle while s_ready is high. Queue state is updated at
//   the accept edge and the storage RAM read is issued there; the RAM's
//   registered read port and the output register give two register stages,
//   and m_valid rises once the word moves on into the output register.
//   A result may sit in the output register while one more operation is
//   accepted into the read stage; with the receiver stalled, s_ready drops
//   once both stages hold a word.
// Reset:
//   aresetn low empties all bands (pointers and counts to zero), loads the
//   default priority map and capacity, and drops any words in flight.
//   Storage contents need no clearing since only written entries are read.
// ============================================================================
module strict_priority_band_queue_core #(
    parameter int NUM_BANDS  = 3,
    parameter int BAND_DEPTH = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [sbq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sbq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sbq_pkg::in_word_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sbq_pkg::out_word_t                 m_data
);

    localparam int AW = $clog2(NUM_BANDS * BAND_DEPTH);

    logic [31:0]         map_reg;
    logic [6:0]          cap_reg;
    logic                st1_valid_reg;
    sbq_pkg::sched_res_t st1_res_reg;
    logic                out_valid_reg;
    sbq_pkg::out_word_t  out_word_reg;

    logic                act, load_out;
    sbq_pkg::sched_res_t res;
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [31:0]         ram_rdata;
    sbq_pkg::out_word_t  out_word_next;

    assign load_out = st1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !st1_valid_reg || load_out;
    assign act      = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg <= sbq_pkg::MAP_RESET;
            cap_reg <= sbq_pkg::CAP_RESET;
        end else if (cfg_we) begin
            if (cfg_index == sbq_pkg::CFG_PRIORITY_MAP) begin
                map_reg <= cfg_wdata[31:0];
            end else if (cfg_index == sbq_pkg::CFG_BAND_CAPACITY) begin
                cap_reg <= cfg_wdata[6:0];
            end
        end
    end

    sbq_sched #(
        .NUM_BANDS  (NUM_BANDS),
        .BAND_DEPTH (BAND_DEPTH)
    ) u_sched (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .act           (act),
        .item          (s_data),
        .priority_map  (map_reg),
        .band_capacity (cap_reg),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr)
    );

    sbq_ram #(
        .WIDTH (32),
        .DEPTH (NUM_BANDS * BAND_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data.packet_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (act) begin
            st1_valid_reg <= 1'b1;
        end else if (load_out) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (act) begin
            st1_res_reg <= res;
        end
    end

    always_comb begin
        out_word_next.accepted  = st1_res_reg.accepted;
        out_word_next.out_valid = st1_res_reg.found;
        out_word_next.out_data  = st1_res_reg.found ? ram_rdata : 32'd0;
        out_word_next.out_band  = st1_res_reg.band;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

/* rtl/sbq_ram.sv */
// ============================================================================
// sbq_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ============================================================================
module sbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sbq_sched.sv */
// ============================================================================
// sbq_sched
// Band selection, per-band pointers and counts, storage addressing.
// ============================================================================
module sbq_sched #(
    parameter int NUM_BANDS  = 3,
    parameter int BAND_DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 act,
    input  sbq_pkg::in_word_t                    item,
    input  logic [31:0]                          priority_map,
    input  logic [6:0]                           band_capacity,
    output sbq_pkg::sched_res_t                  res,
    output logic                                 ram_we,
    output logic [$clog2(NUM_BANDS*BAND_DEPTH)-1:0] ram_waddr,
    output logic                                 ram_re,
    output logic [$clog2(NUM_BANDS*BAND_DEPTH)-1:0] ram_raddr
);

    localparam int BW    = $clog2(NUM_BANDS);
    localparam int PTR_W = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
    localparam int CNT_W = $clog2(BAND_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam int AW    = $clog2(NUM_BANDS * BAND_DEPTH);

    logic [PTR_W-1:0] head_reg  [NUM_BANDS];
    logic [PTR_W-1:0] tail_reg  [NUM_BANDS];
    logic [CNT_W-1:0] count_reg [NUM_BANDS];

    logic             is_enq, is_deq, is_peek;
    logic [BW-1:0]    enq_band, first_band, sel;
    logic             any_nonempty, room;
    logic [CMP_W-1:0] cap_eff;
    logic             do_push, do_pop;
    logic [PTR_W-1:0] head_sel, tail_sel;

    function automatic logic [BW-1:0] map_lookup(input logic [31:0] map,
                                                 input logic [3:0] prio);
        logic [1:0] entry;
        entry = map[{prio, 1'b0} +: 2];
        if ({3'b0, entry} < 5'(NUM_BANDS)) begin
            return BW'(entry);
        end
        return BW'(NUM_BANDS - 1);
    endfunction

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(BAND_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign is_enq  = (item.mode == sbq_pkg::MODE_ENQ);
    assign is_deq  = (item.mode == sbq_pkg::MODE_DEQ);
    assign is_peek = (item.mode == sbq_pkg::MODE_PEEK);

    always_comb begin
        if (item.filter_matched) begin
            if ({1'b0, item.filter_class} < 5'(NUM_BANDS)) begin
                enq_band = BW'(item.filter_class);
            end else begin
                enq_band = map_lookup(priority_map, 4'd0);
            end
        end else if (item.has_priority) begin
            enq_band = map_lookup(priority_map, item.priority_req);
        end else begin
            enq_band = map_lookup(priority_map, 4'd0);
        end
    end

    always_comb begin
        any_nonempty = 1'b0;
        first_band   = '0;
        for (int i = NUM_BANDS - 1; i >= 0; i--) begin
            if (count_reg[i] != '0) begin
                any_nonempty = 1'b1;
                first_band   = BW'(i);
            end
        end
    end

    assign sel      = is_enq ? enq_band : first_band;
    assign head_sel = head_reg[sel];
    assign tail_sel = tail_reg[sel];

    assign cap_eff = (CMP_W'(band_capacity) > CMP_W'(BAND_DEPTH)) ?
                     CMP_W'(BAND_DEPTH) : CMP_W'(band_capacity);
    assign room    = CMP_W'(count_reg[sel]) < cap_eff;

    assign do_push = act && is_enq && room;
    assign do_pop  = act && is_deq && any_nonempty;

    assign ram_we    = do_push;
    assign ram_re    = act && (is_deq || is_peek) && any_nonempty;
    assign ram_waddr = AW'(AW'(sel) * AW'(BAND_DEPTH) + AW'(tail_sel));
    assign ram_raddr = AW'(AW'(sel) * AW'(BAND_DEPTH) + AW'(head_sel));

    always_comb begin
        res.accepted = is_enq && room;
        res.found    = (is_deq || is_peek) && any_nonempty;
        if (is_enq) begin
            res.band = 2'(enq_band);
        end else if (res.found) begin
            res.band = 2'(first_band);
        end else begin
            res.band = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BANDS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            if (do_push) begin
                tail_reg[sel]  <= wrap_next(tail_sel);
                count_reg[sel] <= count_reg[sel] + CNT_W'(1);
            end else if (do_pop) begin
                head_reg[sel]  <= wrap_next(head_sel);
                count_reg[sel] <= count_reg[sel] - CNT_W'(1);
            end
        end
    end

endmodule

/* sim/band_queue_scoreboard.sv */
// ============================================================================
// band_queue_scoreboard
// Watches the operation, result and register ports of the band queue, keeps a
// copy of the band FIFOs and registers, and checks every result word in order.
// ============================================================================
module band_queue_scoreboard
    import sbq_pkg::*;
#(
    parameter int NUM_BANDS  = 3,
    parameter int BAND_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_word_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_word_t             m_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] prio_map;
    logic [6:0]  band_cap;
    logic [31:0] band_store [NUM_BANDS][BAND_DEPTH];
    int          band_head [NUM_BANDS];
    int          band_tail [NUM_BANDS];
    int          band_fill [NUM_BANDS];
    out_word_t   expected_words [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got_v, want_v);
        fail_count++;
    endtask

    function automatic logic [1:0] map_band(input logic [3:0] prio);
        logic [1:0] b;
        b = prio_map[2*prio +: 2];
        if (b >= NUM_BANDS)
            b = 2'(NUM_BANDS - 1);
        return b;
    endfunction

    function automatic out_word_t predict_queue_op(input in_word_t w);
        out_word_t r;
        int        band;
        int        limit;
        r = '0;
        case (w.mode)
            MODE_ENQ: begin
                band = int'(map_band(4'd0));
                if (w.filter_matched) begin
                    if (w.filter_class < NUM_BANDS)
                        band = int'(w.filter_class);
                end else if (w.has_priority) begin
                    band = int'(map_band(w.priority_req));
                end
                limit = (band_cap > BAND_DEPTH) ? BAND_DEPTH : int'(band_cap);
                r.out_band = band[1:0];
                if (band_fill[band] < limit) begin
                    band_store[band][band_tail[band]] = w.packet_data;
                    band_tail[band] = (band_tail[band] + 1 >= BAND_DEPTH) ?
                                      0 : band_tail[band] + 1;
                    band_fill[band]++;
                    r.accepted = 1'b1;
                end
            end
            MODE_DEQ, MODE_PEEK: begin
                band = -1;
                for (int i = NUM_BANDS - 1; i >= 0; i--)
                    if (band_fill[i] != 0)
                        band = i;
                if (band >= 0) begin
                    r.out_valid = 1'b1;
                    r.out_data  = band_store[band][band_head[band]];
                    r.out_band  = band[1:0];
                    if (w.mode == MODE_DEQ) begin
                        band_head[band] = (band_head[band] + 1 >= BAND_DEPTH) ?
                                          0 : band_head[band] + 1;
                        band_fill[band]--;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            prio_map = MAP_RESET;
            band_cap = CAP_RESET;
            for (int i = 0; i < NUM_BANDS; i++) begin
                band_head[i] = 0;
                band_tail[i] = 0;
                band_fill[i] = 0;
            end
            expected_words.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_PRIORITY_MAP)
                    prio_map = cfg_wdata;
                else if (cfg_index == CFG_BAND_CAPACITY)
                    band_cap = cfg_wdata[6:0];
            end
            if (s_valid && s_ready)
                expected_words.push_back(predict_queue_op(s_data));
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", m_data.out_data, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(m_data.accepted),
                                        32'(want.accepted));
                    if (m_data.out_valid !== want.out_valid)
                        report_mismatch("out_valid", 32'(m_data.out_valid),
                                        32'(want.out_valid));
                    if (m_data.out_data !== want.out_data)
                        report_mismatch("out_data", m_data.out_data, want.out_data);
                    if (m_data.out_band !== want.out_band)
                        report_mismatch("out_band", 32'(m_data.out_band),
                                        32'(want.out_band));
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

/* sim/strict_priority_band_queue_core_tb.sv */
// ============================================================================
// strict_priority_band_queue_core_tb
// Drives enqueue, dequeue, peek and unused-mode words into the band queue under
// several register settings and handshake idling patterns; the scoreboard checks.
// ============================================================================
module strict_priority_band_queue_core_tb;
    import sbq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BANDS      = 3;
    localparam int BAND_DEPTH     = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;

    int fail_count;
    int pending;
    int send_idle_pct;
    int stall_pct;
    int idle_cycles;

    strict_priority_band_queue_core #(
        .NUM_BANDS (NUM_BANDS),
        .BAND_DEPTH(BAND_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    band_queue_scoreboard #(
        .NUM_BANDS (NUM_BANDS),
        .BAND_DEPTH(BAND_DEPTH)
    ) scoreboard (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic in_word_t op_word(input logic [1:0] mode, input logic [31:0] data,
                                         input logic has_p, input logic [3:0] prio,
                                         input logic matched, input logic [3:0] fclass);
        in_word_t w;
        w.mode           = mode;
        w.packet_data    = data;
        w.has_priority   = has_p;
        w.priority_req   = prio;
        w.filter_matched = matched;
        w.filter_class   = fclass;
        return w;
    endfunction

    function automatic in_word_t random_op(input int enq_pct);
        logic [1:0] mode;
        int         r;
        r = $urandom_range(99);
        if (r < enq_pct)
            mode = MODE_ENQ;
        else begin
            r = $urandom_range(99);
            mode = (r < 75) ? MODE_DEQ : (r < 90) ? MODE_PEEK : MODE_UNUSED;
        end
        return op_word(mode, $urandom, 1'($urandom_range(1)), 4'($urandom_range(15)),
                       $urandom_range(3) == 0, 4'($urandom_range(15)));
    endfunction

    // entered and left at a falling edge; valid stays up for a following word
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic drain_queue();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_block(input logic [31:0] map, input logic [6:0] cap,
                             input int enq_pct, input int n_words, input int phase);
        drain_queue();
        write_reg(CFG_PRIORITY_MAP, map);
        write_reg(CFG_BAND_CAPACITY, 32'(cap));
        case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 52; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 52; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
        endcase
        for (int i = 0; i < n_words; i++) begin
            if (i == n_words / 2)
                drain_queue();
            send_word(random_op(enq_pct));
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_PRIORITY_MAP;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty queue, unused mode, band selection under the default map
        send_word(op_word(MODE_DEQ,    32'h1234_5678, 1'b1, 4'd3,  1'b0, 4'd0));
        send_word(op_word(MODE_PEEK,   32'hFFFF_FFFF, 1'b0, 4'd0,  1'b1, 4'd1));
        send_word(op_word(MODE_UNUSED, 32'hDEAD_BEEF, 1'b1, 4'd15, 1'b1, 4'd15));
        send_word(op_word(MODE_ENQ,    32'hFFFF_FFFF, 1'b1, 4'd0,  1'b1, 4'd2));
        send_word(op_word(MODE_ENQ,    32'h0000_0000, 1'b1, 4'd2,  1'b1, 4'd15));
        send_word(op_word(MODE_ENQ,    32'hA5A5_A5A5, 1'b1, 4'd15, 1'b0, 4'd0));
        send_word(op_word(MODE_ENQ,    32'h5A5A_5A5A, 1'b1, 4'd2,  1'b0, 4'd9));
        send_word(op_word(MODE_ENQ,    32'h0F0F_F0F0, 1'b0, 4'd15, 1'b0, 4'd1));
        send_word(op_word(MODE_PEEK,   32'h0,         1'b0, 4'd0,  1'b0, 4'd0));
        repeat (6)
            send_word(op_word(MODE_DEQ, 32'h0, 1'b0, 4'd0, 1'b0, 4'd0));

        // saturated map entries and single-word capacity
        drain_queue();
        write_reg(CFG_PRIORITY_MAP, 32'hFFFF_FFFF);
        write_reg(CFG_BAND_CAPACITY, 32'd1);
        send_word(op_word(MODE_ENQ,  32'h1111_1111, 1'b1, 4'd7, 1'b0, 4'd0));
        send_word(op_word(MODE_ENQ,  32'h2222_2222, 1'b1, 4'd7, 1'b0, 4'd0));
        send_word(op_word(MODE_ENQ,  32'h3333_3333, 1'b0, 4'd0, 1'b1, 4'd3));
        send_word(op_word(MODE_ENQ,  32'h4444_4444, 1'b1, 4'd1, 1'b1, 4'd0));
        send_word(op_word(MODE_ENQ,  32'h5555_5555, 1'b0, 4'd0, 1'b1, 4'd0));
        send_word(op_word(MODE_PEEK, 32'h0,         1'b0, 4'd0, 1'b0, 4'd0));
        repeat (3)
            send_word(op_word(MODE_DEQ, 32'h0, 1'b0, 4'd0, 1'b0, 4'd0));

        run_block(MAP_RESET,    7'd4,   60, 80,  0);
        run_block($urandom,     7'd1,   55, 60,  1);
        run_block(32'h0,        7'd64,  95, 110, 2);
        // band 0 now sits above the lowered capacity
        run_block(32'h0,        7'd2,   20, 110, 3);
        run_block(32'hFFFF_FFFF, 7'd127, 50, 60, 4);
        run_block($urandom,     7'd0,   50, 30,  5);
        run_block($urandom,     7'd8,   50, 60,  6);
        run_block(MAP_RESET,    7'd3,   50, 50,  7);

        drain_queue();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* strict_priority_band_queue_core.f */
rtl/sbq_pkg.sv
rtl/sbq_ram.sv
rtl/sbq_sched.sv
rtl/strict_priority_band_queue_core.sv
sim/band_queue_scoreboard.sv
sim/strict_priority_band_queue_core_tb.sv
